### hdl/slp_pkg.sv
package slp_pkg;

   localparam int MaxLevel = 10;
   localparam int LevelWidth = 4;
   localparam int CountWidth = 12;
   localparam int SampleWidth = 10;

   localparam logic [CountWidth-1:0] StepsPerLevelReset = 12'd1000;

   typedef enum logic [1:0] {
      CMD_SERIAL = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   localparam logic [7:0] ChAuto       = 8'h30;   // '0'
   localparam logic [7:0] ChManual     = 8'h31;   // '1'
   localparam logic [7:0] ChReverseOff = 8'h32;   // '2'
   localparam logic [7:0] ChReverseOn  = 8'h33;   // '3'
   localparam logic [7:0] ChLevelBase  = 8'h61;   // 'a'
   localparam logic [7:0] ChLevelTop   = 8'(ChLevelBase + MaxLevel);

   localparam logic [LevelWidth-1:0] MaxLevelVal = LevelWidth'(MaxLevel);

   typedef struct packed {
      logic [3:0] phase;
      logic       stepped;
      logic [7:0] led_bar;
      logic [3:0] level_now;
      logic       manual_mode;
      logic       reversed;
      logic       busy_res;
   } result_type;

   function automatic logic [7:0] led_pattern(input logic [LevelWidth-1:0] level);
      logic [7:0] pat;
      case (level)
         4'd0:    pat = 8'h00;
         4'd1:    pat = 8'h01;
         4'd2:    pat = 8'h03;
         4'd3:    pat = 8'h07;
         4'd4:    pat = 8'h0F;
         4'd5:    pat = 8'h1F;
         4'd6:    pat = 8'h3F;
         4'd7:    pat = 8'h7F;
         4'd8:    pat = 8'hFF;
         4'd9:    pat = 8'hFE;
         default: pat = 8'hFC;
      endcase
      return pat;
   endfunction

endpackage

### hdl/stepper_level_positioner.sv
// A request's response is registered, in the output register or in the skid entry.
// Throughput: one request per cycle while req_stall is low. One-entry skid stage:
// while a response is stalled one more request goes into the skid entry, then
// req_stall holds off requests until the skid entry moves into the output register.
// Reset: synchronous, active high; clears all motor/level state, empties the
// output stages and loads steps_per_level with 1000.
module stepper_level_positioner
   import slp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [7:0]             req_rx_byte,
   input  logic [SampleWidth-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [3:0]             rsp_phase,
   output logic                   rsp_stepped,
   output logic [7:0]             rsp_led_bar,
   output logic [3:0]             rsp_level_now,
   output logic                   rsp_manual_mode,
   output logic                   rsp_reversed,
   output logic                   rsp_busy_res,
   input  logic                   csr_wr_en,
   input  logic [CountWidth-1:0]  csr_wr_data
);

   logic [CountWidth-1:0] spl_ff;
   logic                  mode_ff, mode_in;
   logic                  rev_ff, rev_in;
   logic [LevelWidth-1:0] target_ff, target_in;
   logic [LevelWidth-1:0] manual_ff, manual_in;
   logic [LevelWidth-1:0] reached_ff, reached_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [1:0]            pidx_ff, pidx_in;
   logic                  started_ff, started_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;
   logic                  skid_valid_ff, skid_valid_in;
   result_type            skid_ff, skid_in;

   logic                  accept;
   logic                  out_free;
   logic                  stepped;
   logic [CountWidth-1:0] count_inc;
   logic [LevelWidth-1:0] sample_level;
   command_type           cmd;
   result_type            result;

   slp_level_map u_level_map (
      .sample   (req_sample),
      .reversed (rev_ff),
      .level    (sample_level)
   );

   assign cmd       = command_type'(req_command);
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_inc = count_ff + 1'b1;

   // next state for one request
   always_comb begin
      mode_in    = mode_ff;
      rev_in     = rev_ff;
      target_in  = target_ff;
      manual_in  = manual_ff;
      reached_in = reached_ff;
      count_in   = count_ff;
      pidx_in    = pidx_ff;
      started_in = started_ff;
      stepped    = 1'b0;

      case (cmd)
         CMD_SERIAL: begin
            if (req_rx_byte == ChAuto) begin
               mode_in = 1'b0;
            end else if (req_rx_byte == ChManual) begin
               if (!mode_ff) begin
                  manual_in = target_ff;
               end
               mode_in = 1'b1;
            end else if (req_rx_byte == ChReverseOff) begin
               rev_in = 1'b0;
            end else if (req_rx_byte == ChReverseOn) begin
               rev_in = 1'b1;
            end else if (req_rx_byte >= ChLevelBase && req_rx_byte <= ChLevelTop) begin
               manual_in = LevelWidth'(req_rx_byte - ChLevelBase);
            end
         end
         CMD_SAMPLE: begin
            if (!mode_ff && target_ff == reached_ff) begin
               target_in = sample_level;
            end
         end
         CMD_TICK: begin
            if (target_ff != reached_ff) begin
               stepped    = 1'b1;
               started_in = 1'b1;
               // climbing runs the coils in reverse order
               if (target_ff > reached_ff) begin
                  pidx_in = started_ff ? (pidx_ff - 2'd1) : 2'd3;
               end else begin
                  pidx_in = started_ff ? (pidx_ff + 2'd1) : 2'd0;
               end
               count_in = count_inc;
               if (count_inc >= spl_ff) begin
                  count_in = '0;
                  if (target_ff > reached_ff) begin
                     reached_in = reached_ff + 1'b1;
                  end else begin
                     reached_in = reached_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (mode_in && target_in == reached_in) begin
         target_in = manual_in;
      end

      result.phase       = started_in ? (4'd1 << pidx_in) : 4'd0;
      result.stepped     = stepped;
      result.led_bar     = led_pattern(target_in);
      result.level_now   = target_in;
      result.manual_mode = mode_in;
      result.reversed    = rev_in;
      result.busy_res    = (target_in != reached_in);
   end

   // output register with skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            rsp_in       = result;
            rsp_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spl_ff        <= StepsPerLevelReset;
         mode_ff       <= 1'b0;
         rev_ff        <= 1'b0;
         target_ff     <= '0;
         manual_ff     <= '0;
         reached_ff    <= '0;
         count_ff      <= '0;
         pidx_ff       <= '0;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            spl_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff    <= mode_in;
            rev_ff     <= rev_in;
            target_ff  <= target_in;
            manual_ff  <= manual_in;
            reached_ff <= reached_in;
            count_ff   <= count_in;
            pidx_ff    <= pidx_in;
            started_ff <= started_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phase       = rsp_ff.phase;
   assign rsp_stepped     = rsp_ff.stepped;
   assign rsp_led_bar     = rsp_ff.led_bar;
   assign rsp_level_now   = rsp_ff.level_now;
   assign rsp_manual_mode = rsp_ff.manual_mode;
   assign rsp_reversed    = rsp_ff.reversed;
   assign rsp_busy_res    = rsp_ff.busy_res;

endmodule

### hdl/slp_level_map.sv
module slp_level_map
   import slp_pkg::*;
(
   input  logic [SampleWidth-1:0] sample,
   input  logic                   reversed,
   output logic [LevelWidth-1:0]  level
);

   // sample/100 as (sample*1311)>>17, exact over 10 bits
   logic [20:0] prod100;
   logic [3:0]  q100;
   // sample/80 = (sample>>4)/5, the /5 as (x*205)>>10
   logic [13:0] prod80;
   logic [3:0]  q80;

   always_comb begin
      prod100 = 21'(sample) * 21'd1311;
      q100    = prod100[20:17];
      prod80  = 14'(sample[SampleWidth-1:4]) * 14'd205;
      q80     = prod80[13:10];
      if (!reversed) begin
         level = (q100 <= MaxLevelVal) ? q100 : '0;
      end else begin
         level = (q80 >= 4'd1 && q80 <= MaxLevelVal) ? (MaxLevelVal - q80) : MaxLevelVal;
      end
   end

endmodule
